/* rtl/vat_pkg.sv */
// Shared types, constants and the one-quadrant degree table for the atan2 lookup block.
`default_nettype none

package vat_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MAG_W  = 16;   // magnitude of a 16-bit component, 0..32768
    localparam int SQ_W   = 32;   // square of a magnitude
    localparam int RHS_W  = 38;   // 225 * square
    localparam int ACC_W  = 40;   // i*i*len2 and i*len2 accumulators
    localparam int IDX_W  = 4;
    localparam int DEG_W  = 9;
    localparam int NSRCH  = 4;    // one search stage per index bit

    localparam logic [DEG_W-1:0] OFS_Q0 = 9'd0;
    localparam logic [DEG_W-1:0] OFS_Q1 = 9'd90;
    localparam logic [DEG_W-1:0] OFS_Q2 = 9'd180;
    localparam logic [DEG_W-1:0] OFS_Q3 = 9'd270;

    // One item moving through the index search stages.
    typedef struct packed {
        logic               xneg;
        logic               zneg;
        logic               short_vec;
        logic [IDX_W-1:0]   sidx_x;
        logic [IDX_W-1:0]   sidx_z;
        logic [SQ_W-1:0]    len2;
        logic [RHS_W-1:0]   rhs_x;
        logic [RHS_W-1:0]   rhs_z;
        logic [ACC_W-1:0]   p_x;      // idx_x^2 * len2
        logic [ACC_W-1:0]   q_x;      // idx_x * len2
        logic [IDX_W-1:0]   idx_x;
        logic [ACC_W-1:0]   p_z;
        logic [ACC_W-1:0]   q_z;
        logic [IDX_W-1:0]   idx_z;
    } t_srch;

    localparam logic [7:0] DEG_TABLE [16][16] = '{
        '{8'd45, 8'd18, 8'd11, 8'd8,  8'd6,  8'd5,  8'd4,  8'd3,
          8'd3,  8'd3,  8'd2,  8'd2,  8'd2,  8'd1,  8'd0,  8'd0},
        '{8'd71, 8'd45, 8'd30, 8'd23, 8'd18, 8'd15, 8'd12, 8'd11,
          8'd10, 8'd8,  8'd8,  8'd7,  8'd6,  8'd6,  8'd5,  8'd5},
        '{8'd78, 8'd59, 8'd45, 8'd35, 8'd29, 8'd24, 8'd21, 8'd18,
          8'd16, 8'd14, 8'd13, 8'd12, 8'd11, 8'd10, 8'd9,  8'd9},
        '{8'd81, 8'd66, 8'd54, 8'd45, 8'd37, 8'd32, 8'd28, 8'd25,
          8'd22, 8'd20, 8'd18, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12},
        '{8'd83, 8'd71, 8'd60, 8'd52, 8'd45, 8'd39, 8'd34, 8'd30,
          8'd27, 8'd25, 8'd23, 8'd21, 8'd19, 8'd18, 8'd17, 8'd16},
        '{8'd84, 8'd74, 8'd65, 8'd57, 8'd50, 8'd45, 8'd40, 8'd36,
          8'd32, 8'd30, 8'd27, 8'd25, 8'd23, 8'd22, 8'd20, 8'd19},
        '{8'd85, 8'd77, 8'd69, 8'd61, 8'd55, 8'd49, 8'd45, 8'd40,
          8'd37, 8'd34, 8'd31, 8'd29, 8'd27, 8'd25, 8'd24, 8'd22},
        '{8'd86, 8'd78, 8'd71, 8'd65, 8'd59, 8'd53, 8'd49, 8'd45,
          8'd41, 8'd38, 8'd35, 8'd33, 8'd30, 8'd29, 8'd27, 8'd25},
        '{8'd86, 8'd80, 8'd73, 8'd67, 8'd62, 8'd57, 8'd52, 8'd48,
          8'd45, 8'd41, 8'd39, 8'd36, 8'd34, 8'd32, 8'd30, 8'd28},
        '{8'd87, 8'd81, 8'd75, 8'd70, 8'd64, 8'd60, 8'd55, 8'd51,
          8'd48, 8'd45, 8'd42, 8'd39, 8'd37, 8'd35, 8'd33, 8'd31},
        '{8'd87, 8'd82, 8'd76, 8'd71, 8'd67, 8'd62, 8'd58, 8'd54,
          8'd51, 8'd48, 8'd45, 8'd42, 8'd40, 8'd38, 8'd36, 8'd34},
        '{8'd87, 8'd82, 8'd77, 8'd73, 8'd68, 8'd64, 8'd60, 8'd57,
          8'd53, 8'd50, 8'd47, 8'd45, 8'd42, 8'd40, 8'd38, 8'd36},
        '{8'd88, 8'd83, 8'd78, 8'd74, 8'd70, 8'd66, 8'd62, 8'd59,
          8'd56, 8'd52, 8'd50, 8'd47, 8'd45, 8'd43, 8'd40, 8'd39},
        '{8'd89, 8'd83, 8'd79, 8'd75, 8'd71, 8'd67, 8'd64, 8'd61,
          8'd58, 8'd55, 8'd52, 8'd49, 8'd47, 8'd45, 8'd43, 8'd41},
        '{8'd90, 8'd84, 8'd80, 8'd76, 8'd72, 8'd69, 8'd66, 8'd62,
          8'd59, 8'd56, 8'd54, 8'd51, 8'd49, 8'd47, 8'd45, 8'd43},
        '{8'd90, 8'd84, 8'd81, 8'd77, 8'd74, 8'd70, 8'd67, 8'd64,
          8'd61, 8'd58, 8'd56, 8'd53, 8'd51, 8'd49, 8'd47, 8'd45}
    };

endpackage

`default_nettype wire

/* rtl/vector_angle_table_atan2.sv */
// Pipelined atan2 by table: (x, z) fixed-point vector to whole degrees 0..360.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_ready    | i_vec_x[15:0], i_vec_z[15:0]
//  out     | from block| o_out_valid / i_out_ready  | o_angle_deg[8:0]
//
//  Eight register stages: magnitude, squares, length and bounds, four index
//  search stages (one index bit each), table read with quadrant offset.
//  One vector per cycle while the output is not held; each input transfer reaches
//  o_out_valid after passing through all eight register stages in order.
//  All stages advance together; when the output is held and full the whole
//  pipe holds and o_in_ready drops.
//  i_rst_n (synchronous, active low) clears the valid bits only.
`default_nettype none

module vector_angle_table_atan2
    import vat_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_vec_x,
    input  wire logic signed [15:0] i_vec_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [DEG_W-1:0]        o_angle_deg
);

    localparam logic [34:0] ONE2 = 35'd1 << (2 * FRAC_BITS);

    logic en;
    // valid bits: [0] mag, [1] squares, [2] bounds, [3..6] search, [7] output
    logic [7:0] r_vld;

    // stage 1: sign and magnitude
    logic             r1_xneg, r1_zneg;
    logic [MAG_W-1:0] r1_ax, r1_az;
    // stage 2: squares and short-vector indices
    logic             r2_xneg, r2_zneg;
    logic [SQ_W-1:0]  r2_sx, r2_sz;
    logic [IDX_W-1:0] r2_tx, r2_tz;
    logic [20:0]      n2_tx, n2_tz;
    // stages 3..7: search
    t_srch            r_srch [NSRCH+1];
    t_srch            n_srch [NSRCH+1];
    // output stage
    logic [DEG_W-1:0] r_deg;
    logic [1:0]       r_quad;
    logic [IDX_W-1:0] n_ix, n_iz, n_row, n_col;
    logic [DEG_W-1:0] n_ofs, n_deg;

    assign en          = i_out_ready || !r_vld[7];
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[7];
    assign o_angle_deg = r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[6:0], i_in_valid};
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xneg <= i_vec_x[15];
            r1_zneg <= i_vec_z[15];
            r1_ax   <= i_vec_x[15] ? (~i_vec_x + 16'd1) : i_vec_x;
            r1_az   <= i_vec_z[15] ? (~i_vec_z + 16'd1) : i_vec_z;
        end
    end

    // stage 2
    always_comb begin
        n2_tx = ({5'd0, r1_ax} * 21'd30) >> FRAC_BITS;
        n2_tz = ({5'd0, r1_az} * 21'd30) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_xneg <= r1_xneg;
            r2_zneg <= r1_zneg;
            r2_sx   <= {16'd0, r1_ax} * {16'd0, r1_ax};
            r2_sz   <= {16'd0, r1_az} * {16'd0, r1_az};
            r2_tx   <= (n2_tx > 21'd15) ? 4'd15 : n2_tx[IDX_W-1:0];
            r2_tz   <= (n2_tz > 21'd15) ? 4'd15 : n2_tz[IDX_W-1:0];
        end
    end

    // stage 3 builds the search seed; stages 4..7 settle one index bit each,
    // keeping i^2*len2 and i*len2 so a trial is two shifted adds.
    always_comb begin
        logic [ACC_W-1:0] len;
        logic [ACC_W-1:0] trial_x, trial_z;
        logic [IDX_W-1:0] bit_v;
        n_srch[0].xneg      = r2_xneg;
        n_srch[0].zneg      = r2_zneg;
        n_srch[0].short_vec = (({3'd0, r2_sx} * 35'd10) < ONE2)
                           && (({3'd0, r2_sz} * 35'd10) < ONE2);
        n_srch[0].sidx_x    = r2_tx;
        n_srch[0].sidx_z    = r2_tz;
        n_srch[0].len2      = r2_sx + r2_sz;
        n_srch[0].rhs_x     = {6'd0, r2_sx} * 38'd225;
        n_srch[0].rhs_z     = {6'd0, r2_sz} * 38'd225;
        n_srch[0].p_x       = '0;
        n_srch[0].q_x       = '0;
        n_srch[0].idx_x     = '0;
        n_srch[0].p_z       = '0;
        n_srch[0].q_z       = '0;
        n_srch[0].idx_z     = '0;
        for (int s = 1; s <= NSRCH; s++) begin
            n_srch[s] = r_srch[s-1];
            len   = {8'd0, r_srch[s-1].len2};
            bit_v = IDX_W'(1) << (NSRCH - s);
            trial_x = r_srch[s-1].p_x + (r_srch[s-1].q_x << (NSRCH - s + 1))
                    + (len << (2 * (NSRCH - s)));
            trial_z = r_srch[s-1].p_z + (r_srch[s-1].q_z << (NSRCH - s + 1))
                    + (len << (2 * (NSRCH - s)));
            if (trial_x <= {2'd0, r_srch[s-1].rhs_x}) begin
                n_srch[s].p_x   = trial_x;
                n_srch[s].q_x   = r_srch[s-1].q_x + (len << (NSRCH - s));
                n_srch[s].idx_x = r_srch[s-1].idx_x | bit_v;
            end
            if (trial_z <= {2'd0, r_srch[s-1].rhs_z}) begin
                n_srch[s].p_z   = trial_z;
                n_srch[s].q_z   = r_srch[s-1].q_z + (len << (NSRCH - s));
                n_srch[s].idx_z = r_srch[s-1].idx_z | bit_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s <= NSRCH; s++) begin
                r_srch[s] <= n_srch[s];
            end
        end
    end

    // output stage: fold by quadrant, read table, add offset
    always_comb begin
        n_ix = r_srch[NSRCH].short_vec ? r_srch[NSRCH].sidx_x : r_srch[NSRCH].idx_x;
        n_iz = r_srch[NSRCH].short_vec ? r_srch[NSRCH].sidx_z : r_srch[NSRCH].idx_z;
        if (r_srch[NSRCH].xneg == r_srch[NSRCH].zneg) begin
            n_row = n_ix;
            n_col = n_iz;
        end else begin
            n_row = n_iz;
            n_col = n_ix;
        end
        unique case ({r_srch[NSRCH].xneg, r_srch[NSRCH].zneg})
            2'b00:   n_ofs = OFS_Q0;
            2'b01:   n_ofs = OFS_Q1;
            2'b10:   n_ofs = OFS_Q3;
            default: n_ofs = OFS_Q2;
        endcase
        n_deg = {1'b0, DEG_TABLE[n_row][n_col]} + n_ofs;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg  <= n_deg;
            r_quad <= {r_srch[NSRCH].xneg, r_srch[NSRCH].zneg};
        end
    end

    // a held output freezes every valid bit
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_range_pos_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_quad == 2'b00) |-> (o_angle_deg <= 9'd90))
        else $error("first quadrant angle out of range");

    a_range_neg_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_quad == 2'b01)
            |-> (o_angle_deg >= 9'd90 && o_angle_deg <= 9'd180))
        else $error("negative z angle out of range");

    a_range_neg_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_quad[1]) |-> (o_angle_deg >= 9'd180))
        else $error("negative x angle out of range");

endmodule

`default_nettype wire
